// ===== rtl/tas_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the TLV attribute scanner.
// No dependencies; imported by every module of the scanner.
package tas_pkg;

  // Default depth of the result queue, in entries
  localparam int unsigned TAS_OUTQ_DEPTH = 4;

  // Result status codes
  localparam logic [1:0] ST_MATCH     = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_SUMMARY   = 2'd2;

  // Header phase: 0..3 index the next header byte, PHASE_VALUE skips value bytes
  localparam logic [2:0] PHASE_LEN_HI = 3'd3;
  localparam logic [2:0] PHASE_VALUE  = 3'd4;

  // Saturation point of the per-frame match counter
  localparam logic [13:0] MATCH_MAX = 14'h3FFF;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] frame_length;
    logic [15:0] wanted_type;
  } tas_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] value_offset;
    logic [15:0] value_length;
    logic [13:0] match_total;
    logic        frame_valid;
    logic        last;
  } tas_out_t;

  // Results produced by one input beat, in delivery order
  typedef struct packed {
    logic     res0_vld;
    tas_out_t res0;
    logic     res1_vld;
    tas_out_t res1;
  } tas_push_t;

endpackage

// ===== rtl/tas_parse.sv =====
`timescale 1ns / 1ps
// Per-byte attribute parser: frame state registers and the single-pass step.
// Depends on tas_pkg.
module tas_parse
  import tas_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_take,
  input  tas_in_t   in_beat,
  output tas_push_t push
);

  logic [15:0] pos_r, pos_nxt;
  logic [23:0] shift_r, shift_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] value_left_r, value_left_nxt;
  logic        halted_r, halted_nxt;
  logic [13:0] match_r, match_nxt;

  logic [16:0] voff;
  logic [17:0] attr_end;
  logic [15:0] hdr_type;
  logic [15:0] hdr_len;
  logic        is_last;
  logic        overrun;
  logic [15:0] value_left_dec;

  // Decode the header fields completed by this byte
  assign voff      = {1'b0, pos_r} + 17'd1;
  assign hdr_type  = {shift_r[15:8], shift_r[23:16]};
  assign hdr_len   = {in_beat.data_byte, shift_r[7:0]};
  assign attr_end  = {1'b0, voff} + {2'b00, hdr_len};
  assign overrun   = attr_end > {2'b00, in_beat.frame_length};
  assign is_last   = voff >= {1'b0, in_beat.frame_length};
  assign value_left_dec = (value_left_r != 16'd0) ? value_left_r - 16'd1 : value_left_r;

  // Step the parser by one byte and build its results
  always_comb begin
    pos_nxt        = pos_r;
    shift_nxt      = shift_r;
    phase_nxt      = phase_r;
    value_left_nxt = value_left_r;
    halted_nxt     = halted_r;
    match_nxt      = match_r;
    push           = '0;

    if (!halted_r) begin
      if (phase_r >= PHASE_VALUE) begin
        value_left_nxt = value_left_dec;
        if (value_left_dec == 16'd0) begin
          phase_nxt = 3'd0;
        end
      end else if (phase_r < PHASE_LEN_HI) begin
        shift_nxt = {shift_r[15:0], in_beat.data_byte};
        phase_nxt = phase_r + 3'd1;
      end else begin
        shift_nxt = '0;
        if (overrun) begin
          push.res0_vld = 1'b1;
          push.res0     = '{status: ST_MALFORMED, value_offset: voff[15:0],
                            value_length: hdr_len, match_total: match_r,
                            frame_valid: 1'b0, last: 1'b0};
          halted_nxt     = 1'b1;
          phase_nxt      = 3'd0;
          value_left_nxt = '0;
        end else begin
          if (hdr_type == in_beat.wanted_type) begin
            if (match_r < MATCH_MAX) begin
              match_nxt = match_r + 14'd1;
            end
            push.res0_vld = 1'b1;
            push.res0     = '{status: ST_MATCH, value_offset: voff[15:0],
                              value_length: hdr_len, match_total: match_nxt,
                              frame_valid: 1'b1, last: 1'b0};
          end
          if (hdr_len == 16'd0) begin
            phase_nxt = 3'd0;
          end else begin
            phase_nxt      = PHASE_VALUE;
            value_left_nxt = hdr_len;
          end
        end
      end
    end

    // Close the frame: emit the summary and drop all frame state
    if (is_last) begin
      push.res1_vld = 1'b1;
      push.res1     = '{status: ST_SUMMARY, value_offset: 16'd0, value_length: 16'd0,
                        match_total: match_nxt, frame_valid: ~halted_nxt, last: 1'b1};
      pos_nxt        = '0;
      shift_nxt      = '0;
      phase_nxt      = 3'd0;
      value_left_nxt = '0;
      halted_nxt     = 1'b0;
      match_nxt      = '0;
    end else begin
      pos_nxt = voff[15:0];
    end

    if (!in_take) begin
      push.res0_vld = 1'b0;
      push.res1_vld = 1'b0;
    end
  end

  // Advance frame state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      shift_r      <= '0;
      phase_r      <= 3'd0;
      value_left_r <= '0;
      halted_r     <= 1'b0;
      match_r      <= '0;
    end else if (in_take) begin
      pos_r        <= pos_nxt;
      shift_r      <= shift_nxt;
      phase_r      <= phase_nxt;
      value_left_r <= value_left_nxt;
      halted_r     <= halted_nxt;
      match_r      <= match_nxt;
    end
  end

`ifndef SYNTH
  // A halted scan holds no header or value progress
  a_halt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> (phase_r == 3'd0) && (value_left_r == 16'd0))
    else $error("halted scan with live parse state");

  // Value phase always has bytes left to skip
  a_value_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PHASE_VALUE) |-> (value_left_r != 16'd0))
    else $error("value phase with nothing left");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PHASE_VALUE)
    else $error("header phase out of range");

  // A summary restarts the frame at offset zero
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && push.res1_vld) |=> (pos_r == 16'd0) && !halted_r && (match_r == 14'd0))
    else $error("frame state not cleared after summary");
`endif

endmodule

// ===== rtl/tas_outq.sv =====
`timescale 1ns / 1ps
// Result queue: takes up to two results per cycle, delivers one per beat.
// Depends on tas_pkg.
module tas_outq
  import tas_pkg::*;
#(
  parameter int unsigned Depth = TAS_OUTQ_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  tas_push_t push,
  output logic      room2,
  output logic      out_valid,
  input  logic      out_stall,
  output tas_out_t  out_data
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tas_out_t        mem_r [Depth];
  logic [PtrW-1:0] wptr_r, wptr_nxt, wptr_inc;
  logic [PtrW-1:0] rptr_r, rptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic [CntW-1:0] push_n;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rptr_r];
  assign pop       = out_valid && !out_stall;
  assign room2     = (count_r <= CntW'(Depth - 2));
  assign push_n    = CntW'(push.res0_vld) + CntW'(push.res1_vld);
  assign wptr_inc  = ptr_inc(wptr_r);

  // Advance pointers and occupancy
  always_comb begin
    wptr_nxt = wptr_r;
    if (push.res0_vld && push.res1_vld) begin
      wptr_nxt = ptr_inc(wptr_inc);
    end else if (push.res0_vld || push.res1_vld) begin
      wptr_nxt = wptr_inc;
    end
    rptr_nxt  = pop ? ptr_inc(rptr_r) : rptr_r;
    count_nxt = count_r + push_n - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Write results in order; a lone summary takes the first free slot
  always_ff @(posedge clk) begin
    if (push.res0_vld) begin
      mem_r[wptr_r] <= push.res0;
      if (push.res1_vld) begin
        mem_r[wptr_inc] <= push.res1;
      end
    end else if (push.res1_vld) begin
      mem_r[wptr_r] <= push.res1;
    end
  end

`ifndef SYNTH
  // Never push beyond the free space
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != '0) |-> ({1'b0, count_r} + {1'b0, push_n} <= (CntW + 1)'(Depth)))
    else $error("result queue overflow");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(Depth))
    else $error("result queue count out of range");

  // Hold a stalled result beat
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
`endif

endmodule

// ===== rtl/tlv_attribute_scanner.sv =====
`timescale 1ns / 1ps
// TLV attribute scanner top level: one frame byte per input beat.
// Results are registered in the queue; in_stall rises below two free entries.
// Throughput: one byte per cycle while in_stall is low; a frame's final byte
//   may carry two results, which leave on two successive beats.
// Reset (rst_n low, synchronous) clears frame state and empties the queue.
// Depends on tas_pkg, tas_parse, tas_outq.
module tlv_attribute_scanner
  import tas_pkg::*;
#(
  parameter int unsigned OutqDepth = TAS_OUTQ_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  tas_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output tas_out_t out_data
);

  tas_push_t push;
  logic      room2;
  logic      in_take;

  // Take a beat only when both results of a frame end can be queued
  assign in_stall = ~room2;
  assign in_take  = in_valid && room2;

  tas_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_take (in_take),
    .in_beat (in_data),
    .push    (push)
  );

  tas_outq #(
    .Depth (OutqDepth)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room2     (room2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== bench/tb_tlv_attribute_scanner.sv =====
`timescale 1ns / 1ps
// Self-checking bench for tlv_attribute_scanner: a directed table of frames, then
// random attribute chains, with bursty input valid and output stall.
// Depends on tas_pkg and the scanner RTL; reads no files.
module tb_tlv_attribute_scanner;
  import tas_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RANDOM_BEATS = 1750;
  localparam int QUIET_FROM   = 1450;
  localparam int PAUSE_EVERY  = 500;
  localparam int HANG_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int TYPED_NONE   = -1;
  localparam logic [2:0] PHASE_TYPE_LO = 3'd0;

  typedef struct {
    tas_in_t  stim;
    int       n_typed;
    tas_out_t e0;
    tas_out_t e1;
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  tas_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  tas_out_t out_data;

  bit       idle_on;
  int       mismatch_count = 0;
  int       stall_left = 0;
  int       hang_count = 0;
  tas_out_t pending_results[$];
  tas_in_t  frame_beats[$];
  dir_row_t dir_rows[$];

  // Scanner state as the predictor tracks it
  logic [15:0] sc_pos;
  logic [23:0] sc_hdr;
  logic [2:0]  sc_phase;
  logic [15:0] sc_left;
  logic        sc_halted;
  logic [13:0] sc_matches;

  tlv_attribute_scanner dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic tas_out_t make_result(logic [1:0] st, logic [15:0] off,
                                           logic [15:0] len, logic [13:0] total,
                                           logic valid, logic fin);
    tas_out_t r;
    r.status       = st;
    r.value_offset = off;
    r.value_length = len;
    r.match_total  = total;
    r.frame_valid  = valid;
    r.last         = fin;
    return r;
  endfunction

  task automatic clear_scan();
    sc_pos     = '0;
    sc_hdr     = '0;
    sc_phase   = PHASE_TYPE_LO;
    sc_left    = '0;
    sc_halted  = 1'b0;
    sc_matches = '0;
  endtask

  // Advance the scan by one byte and return the results it causes
  task automatic scan_byte(input tas_in_t d, output int n, output tas_out_t r0,
                           output tas_out_t r1);
    tas_out_t    found[2];
    logic [15:0] atype;
    logic [15:0] alen;
    logic [17:0] voff;
    logic        fin;
    n = 0;
    found[0] = '0;
    found[1] = '0;
    fin = ({1'b0, sc_pos} + 17'd1) >= {1'b0, d.frame_length};
    if (!sc_halted) begin
      if (sc_phase >= PHASE_VALUE) begin
        // skip value bytes
        if (sc_left != 16'd0) sc_left = sc_left - 16'd1;
        if (sc_left == 16'd0) sc_phase = PHASE_TYPE_LO;
      end else if (sc_phase < PHASE_LEN_HI) begin
        sc_hdr   = {sc_hdr[15:0], d.data_byte};
        sc_phase = sc_phase + 3'd1;
      end else begin
        // header complete: little-endian type and length
        atype  = {sc_hdr[15:8], sc_hdr[23:16]};
        alen   = {d.data_byte, sc_hdr[7:0]};
        voff   = {2'b00, sc_pos} + 18'd1;
        sc_hdr = '0;
        if (voff + {2'b00, alen} > {2'b00, d.frame_length}) begin
          found[n] = make_result(ST_MALFORMED, voff[15:0], alen, sc_matches, 1'b0, 1'b0);
          n++;
          sc_halted = 1'b1;
          sc_phase  = PHASE_TYPE_LO;
          sc_left   = '0;
        end else begin
          if (atype == d.wanted_type) begin
            if (sc_matches < MATCH_MAX) sc_matches = sc_matches + 14'd1;
            found[n] = make_result(ST_MATCH, voff[15:0], alen, sc_matches, 1'b1, 1'b0);
            n++;
          end
          if (alen == 16'd0) begin
            sc_phase = PHASE_TYPE_LO;
          end else begin
            sc_phase = PHASE_VALUE;
            sc_left  = alen;
          end
        end
      end
    end
    if (fin) begin
      found[n] = make_result(ST_SUMMARY, 16'd0, 16'd0, sc_matches, !sc_halted, 1'b1);
      n++;
      clear_scan();
    end else begin
      sc_pos = sc_pos + 16'd1;
    end
    r0 = found[0];
    r1 = found[1];
  endtask

  function automatic void dir_add(logic [7:0] b, logic [15:0] flen, logic [15:0] want,
                                  int n_typed, tas_out_t e0, tas_out_t e1);
    dir_row_t row;
    row.stim.data_byte    = b;
    row.stim.frame_length = flen;
    row.stim.wanted_type  = want;
    row.n_typed = n_typed;
    row.e0 = e0;
    row.e1 = e1;
    dir_rows.push_back(row);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Offer one input beat, hold it until accepted, then queue its results
  task automatic send_beat(input tas_in_t d, input int n_typed, input tas_out_t e0,
                           input tas_out_t e1);
    int       n;
    tas_out_t r0;
    tas_out_t r1;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    scan_byte(d, n, r0, r1);
    if (n_typed != TYPED_NONE) begin
      n  = n_typed;
      r0 = e0;
      r1 = e1;
    end
    if (n > 0) pending_results.push_back(r0);
    if (n > 1) pending_results.push_back(r1);
    @(negedge clk);
  endtask

  // Hold off the sender until every queued result has come out
  task automatic drain_wait();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Build one random frame into frame_beats
  task automatic build_frame();
    int          kind;
    int          flen;
    int          room;
    int          avail;
    int          len;
    int          cut;
    logic [15:0] want;
    logic [15:0] atype;
    logic [15:0] new_len;
    logic [7:0]  bytes[$];
    tas_in_t     d;
    kind = $urandom_range(0, 9);
    want = $urandom_range(0, 65535);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: flen = $urandom_range(1, 24);
      6, 7, 8:          flen = $urandom_range(25, 80);
      default:          flen = $urandom_range(81, 400);
    endcase
    if (kind == 0) begin
      // zero frame length: every byte is a frame of its own
      repeat ($urandom_range(1, 4)) begin
        d.data_byte    = $urandom_range(0, 255);
        d.frame_length = 16'd0;
        d.wanted_type  = want;
        frame_beats.push_back(d);
      end
      return;
    end
    if (kind == 1) begin
      // noise biased toward small codes so some headers fit and match
      flen = $urandom_range(1, 40);
      want = $urandom_range(0, 1) ? 16'h0000 : 16'h0101;
      repeat (flen) begin
        case ($urandom_range(0, 2))
          0:       bytes.push_back(8'h00);
          1:       bytes.push_back(8'h01);
          default: bytes.push_back($urandom_range(0, 255));
        endcase
      end
    end else begin
      // well-formed chain with the odd overrun and a short tail
      while (bytes.size() < flen) begin
        room = flen - bytes.size();
        if (room < 4) begin
          bytes.push_back($urandom_range(0, 255));
        end else begin
          atype = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 65535)) : want;
          avail = room - 4;
          case ($urandom_range(0, 19))
            0:       len = avail + $urandom_range(1, 3);
            1:       len = $urandom_range(0, 65535);
            2, 3:    len = avail;
            default: len = $urandom_range(0, (avail < 6) ? avail : 6);
          endcase
          bytes.push_back(atype[7:0]);
          bytes.push_back(atype[15:8]);
          bytes.push_back(len[7:0]);
          bytes.push_back(len[15:8]);
          for (int i = 0; i < len && bytes.size() < flen; i++)
            bytes.push_back($urandom_range(0, 255));
        end
      end
    end
    cut     = (kind == 2) ? $urandom_range(0, bytes.size() - 1) : bytes.size();
    new_len = $urandom_range(0, 65535);
    foreach (bytes[i]) begin
      d.data_byte    = bytes[i];
      d.frame_length = (i >= cut) ? new_len : 16'(flen);
      d.wanted_type  = want;
      frame_beats.push_back(d);
    end
    if (kind == 2) begin
      // close whatever frame the length change left open
      d.data_byte    = $urandom_range(0, 255);
      d.frame_length = 16'd0;
      frame_beats.push_back(d);
    end
  endtask

  // Receiver: stall in random bursts while idling is on
  always @(negedge clk) begin
    if (!rst_n || !idle_on) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 11);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check each accepted result beat against the oldest expectation
  always @(posedge clk) begin : check_out
    tas_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", out_data.status, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status != want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.value_offset != want.value_offset)
          report_mismatch("value_offset", out_data.value_offset, want.value_offset);
        if (out_data.value_length != want.value_length)
          report_mismatch("value_length", out_data.value_length, want.value_length);
        if (out_data.match_total != want.match_total)
          report_mismatch("match_total", out_data.match_total, want.match_total);
        if (out_data.frame_valid != want.frame_valid)
          report_mismatch("frame_valid", out_data.frame_valid, want.frame_valid);
        if (out_data.last != want.last)
          report_mismatch("last", out_data.last, want.last);
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      hang_count <= 0;
    end else if (hang_count >= HANG_LIMIT) begin
      $display("tb_tlv_attribute_scanner: errors");
      $finish;
    end else begin
      hang_count <= hang_count + 1;
    end
  end

  initial begin
    int sent;
    int next_pause;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    idle_on  = 1'b1;
    clear_scan();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // single-byte frame right after reset
    dir_add(8'hFF, 16'd1, 16'h0000, 1,
            make_result(ST_SUMMARY, 16'd0, 16'd0, 14'd0, 1'b1, 1'b1), '0);
    // zero frame length
    dir_add(8'h00, 16'd0, 16'hFFFF, 1,
            make_result(ST_SUMMARY, 16'd0, 16'd0, 14'd0, 1'b1, 1'b1), '0);
    // header completing on the last byte: match plus summary
    dir_add(8'h34, 16'd4, 16'h1234, 0, '0, '0);
    dir_add(8'h12, 16'd4, 16'h1234, 0, '0, '0);
    dir_add(8'h00, 16'd4, 16'h1234, 0, '0, '0);
    dir_add(8'h00, 16'd4, 16'h1234, 2,
            make_result(ST_MATCH, 16'd4, 16'd0, 14'd1, 1'b1, 1'b0),
            make_result(ST_SUMMARY, 16'd0, 16'd0, 14'd1, 1'b1, 1'b1));
    // maximum length overruns the frame, scan halts
    dir_add(8'hFF, 16'd6, 16'h0000, 0, '0, '0);
    dir_add(8'hFF, 16'd6, 16'h0000, 0, '0, '0);
    dir_add(8'hFF, 16'd6, 16'h0000, 0, '0, '0);
    dir_add(8'hFF, 16'd6, 16'h0000, 1,
            make_result(ST_MALFORMED, 16'd4, 16'hFFFF, 14'd0, 1'b0, 1'b0), '0);
    dir_add(8'h00, 16'd6, 16'h0000, 0, '0, '0);
    dir_add(8'h00, 16'd6, 16'h0000, 1,
            make_result(ST_SUMMARY, 16'd0, 16'd0, 14'd0, 1'b0, 1'b1), '0);
    // short tail dropped at frame end
    dir_add(8'hAB, 16'd3, 16'h00FF, TYPED_NONE, '0, '0);
    dir_add(8'hCD, 16'd3, 16'h00FF, TYPED_NONE, '0, '0);
    dir_add(8'hEF, 16'd3, 16'h00FF, TYPED_NONE, '0, '0);
    // frame length changes mid-frame
    dir_add(8'hAA, 16'hFFFF, 16'hFFFF, TYPED_NONE, '0, '0);
    dir_add(8'h55, 16'hFFFF, 16'hFFFF, TYPED_NONE, '0, '0);
    dir_add(8'h0F, 16'd3, 16'hFFFF, TYPED_NONE, '0, '0);
    // match with one value byte, then a partial header
    dir_add(8'h01, 16'd7, 16'h0001, TYPED_NONE, '0, '0);
    dir_add(8'h00, 16'd7, 16'h0001, TYPED_NONE, '0, '0);
    dir_add(8'h01, 16'd7, 16'h0001, TYPED_NONE, '0, '0);
    dir_add(8'h00, 16'd7, 16'h0001, TYPED_NONE, '0, '0);
    dir_add(8'h5A, 16'd7, 16'h0001, TYPED_NONE, '0, '0);
    dir_add(8'h7E, 16'd7, 16'h0001, TYPED_NONE, '0, '0);
    dir_add(8'h81, 16'd7, 16'h0001, TYPED_NONE, '0, '0);

    foreach (dir_rows[i])
      send_beat(dir_rows[i].stim, dir_rows[i].n_typed, dir_rows[i].e0, dir_rows[i].e1);
    drain_wait();

    // random frames; idling drops out near the end
    sent       = 0;
    next_pause = PAUSE_EVERY;
    while (sent < RANDOM_BEATS) begin
      idle_on = (sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      if (sent >= next_pause) begin
        drain_wait();
        next_pause += PAUSE_EVERY;
      end
      build_frame();
      while (frame_beats.size() > 0) begin
        send_beat(frame_beats.pop_front(), TYPED_NONE, '0, '0);
        sent++;
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("tb_tlv_attribute_scanner: clean");
    end else begin
      $display("tb_tlv_attribute_scanner: errors");
    end
    $finish;
  end

endmodule
